// ----- rtl/keyed_run_admission_table_macros.svh -----
// assertion macros for the keyed run admission table
// used by the top level only, no other dependencies
`ifndef KEYED_RUN_ADMISSION_TABLE_MACROS_SVH
`define KEYED_RUN_ADMISSION_TABLE_MACROS_SVH

// same-cycle implication
`define KRA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keyed_run_admission_table: check failed");

// next-cycle implication
`define KRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keyed_run_admission_table: check failed");

`endif

// ----- rtl/kra_pkg.sv -----
// shared constants, status codes and control structs for the admission table
// no dependencies
`default_nettype none

package kra_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int KEY_W         = 32;
   localparam int EPOCH_W       = 32;
   localparam int TIME_W        = 48;
   localparam int STATUS_W      = 3;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_ADDR_W    = 4;

   localparam logic [IDX_W-1:0]  LAST_IDX           = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [TIME_W-1:0] MIN_INTERVAL_RESET = TIME_W'(64'd900000000);

   localparam logic OP_REQUEST  = 1'b0;
   localparam logic OP_COMPLETE = 1'b1;

   // register index taken from paddr[3]
   localparam logic CSR_IDX_MIN_INTERVAL = 1'b0;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ADMITTED  = 3'd0,
      STATUS_COALESCED = 3'd1,
      STATUS_NOT_DUE   = 3'd2,
      STATUS_COMPLETED = 3'd3,
      STATUS_REJECTED  = 3'd4,
      STATUS_FULL      = 3'd5
   } status_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } kra_cmd_type;

   typedef struct packed {
      logic scan_last;
   } kra_sts_type;

endpackage

`default_nettype wire

// ----- rtl/kra_ram.sv -----
// generic single-port-write ram with registered read
// no dependencies
`default_nettype none

module kra_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/kra_ctrl.sv -----
// controller: sequences load, table scan, evaluation and commit of one item
// depends on kra_pkg
`default_nettype none

module kra_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output kra_pkg::kra_cmd_type      cmd,
   input  wire kra_pkg::kra_sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EVAL,
      ST_DECIDE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/kra_dp.sv -----
// datapath: key, epoch and time stores, valid bits, scan search and decision
// depends on kra_pkg and kra_ram
`default_nettype none

module kra_dp (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire kra_pkg::kra_cmd_type             cmd,
   output kra_pkg::kra_sts_type                  sts,
   input  wire logic                             req_operation,
   input  wire logic [kra_pkg::KEY_W-1:0]        req_root_key,
   input  wire logic [kra_pkg::EPOCH_W-1:0]      req_run_epoch,
   input  wire logic                             req_trigger_is_interval,
   input  wire logic [kra_pkg::TIME_W-1:0]       req_now_us,
   input  wire logic [kra_pkg::TIME_W-1:0]       min_interval,
   output logic      [kra_pkg::STATUS_W-1:0]     rsp_status
);

   localparam int N  = kra_pkg::TABLE_ENTRIES;
   localparam int IW = kra_pkg::IDX_W;
   localparam int TW = kra_pkg::TIME_W;

   // latched item
   logic                        op_ff, op_in;
   logic [kra_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [kra_pkg::EPOCH_W-1:0] epoch_ff, epoch_in;
   logic                        intv_ff, intv_in;
   logic [TW-1:0]               now_ff, now_in;

   // scan pipeline
   logic [IW-1:0] addr_ff, addr_in;
   logic          cmp_valid_ff, cmp_valid_in;
   logic [IW-1:0] cmp_idx_ff, cmp_idx_in;

   // valid bits
   logic [N-1:0] act_valid_ff, act_valid_in;
   logic [N-1:0] hist_valid_ff, hist_valid_in;

   // search results
   logic          a_found_ff, a_found_in;
   logic [IW-1:0] a_idx_ff, a_idx_in;
   logic          a_newer_ff, a_newer_in;
   logic          a_match_ff, a_match_in;
   logic          h_found_ff, h_found_in;
   logic [IW-1:0] h_idx_ff, h_idx_in;
   logic [TW-1:0] h_time_ff, h_time_in;
   logic          fa_found_ff, fa_found_in;
   logic [IW-1:0] fa_idx_ff, fa_idx_in;
   logic          fh_found_ff, fh_found_in;
   logic [IW-1:0] fh_idx_ff, fh_idx_in;

   logic [TW:0]   elapsed_ff, elapsed_in;
   logic [kra_pkg::STATUS_W-1:0] status_ff, status_in;

   // store ports
   logic [kra_pkg::KEY_W-1:0]   act_key_rd, hist_key_rd;
   logic [kra_pkg::EPOCH_W-1:0] act_epoch_rd;
   logic [TW-1:0]               hist_time_rd;

   logic                        act_key_we, act_epoch_we, hist_key_we, hist_time_we;
   logic [IW-1:0]               act_key_wa, act_epoch_wa, hist_key_wa, hist_time_wa;

   // decision
   kra_pkg::status_type decision;
   logic                do_admit, do_refresh, do_free;
   logic [IW-1:0]       h_slot;
   logic                h_slot_ok;
   logic                not_due;

   kra_ram #(.WIDTH(kra_pkg::KEY_W), .DEPTH(N)) u_act_key (
      .clock   (clock),
      .wr_en   (act_key_we),
      .wr_addr (act_key_wa),
      .wr_data (key_ff),
      .rd_addr (addr_ff),
      .rd_data (act_key_rd)
   );

   kra_ram #(.WIDTH(kra_pkg::EPOCH_W), .DEPTH(N)) u_act_epoch (
      .clock   (clock),
      .wr_en   (act_epoch_we),
      .wr_addr (act_epoch_wa),
      .wr_data (epoch_ff),
      .rd_addr (addr_ff),
      .rd_data (act_epoch_rd)
   );

   kra_ram #(.WIDTH(kra_pkg::KEY_W), .DEPTH(N)) u_hist_key (
      .clock   (clock),
      .wr_en   (hist_key_we),
      .wr_addr (hist_key_wa),
      .wr_data (key_ff),
      .rd_addr (addr_ff),
      .rd_data (hist_key_rd)
   );

   kra_ram #(.WIDTH(TW), .DEPTH(N)) u_hist_time (
      .clock   (clock),
      .wr_en   (hist_time_we),
      .wr_addr (hist_time_wa),
      .wr_data (now_ff),
      .rd_addr (addr_ff),
      .rd_data (hist_time_rd)
   );

   assign sts.scan_last = (addr_ff == kra_pkg::LAST_IDX);
   assign rsp_status    = status_ff;

   // item capture and scan search
   always_comb begin
      op_in        = op_ff;
      key_in       = key_ff;
      epoch_in     = epoch_ff;
      intv_in      = intv_ff;
      now_in       = now_ff;
      addr_in      = addr_ff;
      cmp_valid_in = cmd.scan;
      cmp_idx_in   = addr_ff;
      a_found_in   = a_found_ff;
      a_idx_in     = a_idx_ff;
      a_newer_in   = a_newer_ff;
      a_match_in   = a_match_ff;
      h_found_in   = h_found_ff;
      h_idx_in     = h_idx_ff;
      h_time_in    = h_time_ff;
      fa_found_in  = fa_found_ff;
      fa_idx_in    = fa_idx_ff;
      fh_found_in  = fh_found_ff;
      fh_idx_in    = fh_idx_ff;
      if (cmd.load) begin
         op_in       = req_operation;
         key_in      = req_root_key;
         epoch_in    = req_run_epoch;
         intv_in     = req_trigger_is_interval;
         now_in      = req_now_us;
         addr_in     = '0;
         a_found_in  = 1'b0;
         h_found_in  = 1'b0;
         fa_found_in = 1'b0;
         fh_found_in = 1'b0;
      end else begin
         if (cmd.scan) begin
            addr_in = addr_ff + 1'b1;
         end
         if (cmp_valid_ff) begin
            if (!a_found_ff && act_valid_ff[cmp_idx_ff] && act_key_rd == key_ff) begin
               a_found_in = 1'b1;
               a_idx_in   = cmp_idx_ff;
               a_newer_in = epoch_ff > act_epoch_rd;
               a_match_in = epoch_ff == act_epoch_rd;
            end
            if (!h_found_ff && hist_valid_ff[cmp_idx_ff] && hist_key_rd == key_ff) begin
               h_found_in = 1'b1;
               h_idx_in   = cmp_idx_ff;
               h_time_in  = hist_time_rd;
            end
            if (!fa_found_ff && !act_valid_ff[cmp_idx_ff]) begin
               fa_found_in = 1'b1;
               fa_idx_in   = cmp_idx_ff;
            end
            if (!fh_found_ff && !hist_valid_ff[cmp_idx_ff]) begin
               fh_found_in = 1'b1;
               fh_idx_in   = cmp_idx_ff;
            end
         end
      end
   end

   // elapsed time, msb set when the clock went backwards
   assign elapsed_in = {1'b0, now_ff} - {1'b0, h_time_ff};

   always_comb begin
      not_due    = elapsed_ff[TW] || (elapsed_ff[TW-1:0] < min_interval);
      h_slot     = h_found_ff ? h_idx_ff : fh_idx_ff;
      h_slot_ok  = h_found_ff || fh_found_ff;
      decision   = kra_pkg::STATUS_REJECTED;
      do_admit   = 1'b0;
      do_refresh = 1'b0;
      do_free    = 1'b0;
      if (op_ff == kra_pkg::OP_COMPLETE) begin
         if (a_found_ff && a_match_ff) begin
            decision = kra_pkg::STATUS_COMPLETED;
            do_free  = 1'b1;
         end
      end else if (a_found_ff) begin
         decision   = kra_pkg::STATUS_COALESCED;
         do_refresh = a_newer_ff;
      end else if (intv_ff && h_found_ff && not_due) begin
         decision = kra_pkg::STATUS_NOT_DUE;
      end else if (!fa_found_ff || !h_slot_ok) begin
         decision = kra_pkg::STATUS_FULL;
      end else begin
         decision = kra_pkg::STATUS_ADMITTED;
         do_admit = 1'b1;
      end
   end

   // store writes on commit
   always_comb begin
      act_key_we    = cmd.commit && do_admit;
      act_key_wa    = fa_idx_ff;
      act_epoch_we  = cmd.commit && (do_admit || do_refresh);
      act_epoch_wa  = do_admit ? fa_idx_ff : a_idx_ff;
      hist_key_we   = cmd.commit && do_admit;
      hist_key_wa   = h_slot;
      hist_time_we  = cmd.commit && (do_admit || (do_refresh && h_found_ff));
      hist_time_wa  = do_admit ? h_slot : h_idx_ff;
      act_valid_in  = act_valid_ff;
      hist_valid_in = hist_valid_ff;
      status_in     = status_ff;
      if (cmd.commit) begin
         status_in = decision;
         if (do_admit) begin
            act_valid_in[fa_idx_ff] = 1'b1;
            hist_valid_in[h_slot]   = 1'b1;
         end
         if (do_free) begin
            act_valid_in[a_idx_ff] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff  <= 1'b0;
         act_valid_ff  <= '0;
         hist_valid_ff <= '0;
         a_found_ff    <= 1'b0;
         h_found_ff    <= 1'b0;
         fa_found_ff   <= 1'b0;
         fh_found_ff   <= 1'b0;
         addr_ff       <= '0;
      end else begin
         cmp_valid_ff  <= cmp_valid_in;
         act_valid_ff  <= act_valid_in;
         hist_valid_ff <= hist_valid_in;
         a_found_ff    <= a_found_in;
         h_found_ff    <= h_found_in;
         fa_found_ff   <= fa_found_in;
         fh_found_ff   <= fh_found_in;
         addr_ff       <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      epoch_ff   <= epoch_in;
      intv_ff    <= intv_in;
      now_ff     <= now_in;
      cmp_idx_ff <= cmp_idx_in;
      a_idx_ff   <= a_idx_in;
      a_newer_ff <= a_newer_in;
      a_match_ff <= a_match_in;
      h_idx_ff   <= h_idx_in;
      h_time_ff  <= h_time_in;
      fa_idx_ff  <= fa_idx_in;
      fh_idx_ff  <= fh_idx_in;
      elapsed_ff <= elapsed_in;
      status_ff  <= status_in;
   end

endmodule

`default_nettype wire

// ----- rtl/keyed_run_admission_table.sv -----
// items are handled one at a time; req_stall holds off a new item until the current one commits
// the search is a one-entry-a-cycle scan through the single read port of the key, epoch and
//   time stores
// a new item is taken while an earlier result still waits in the output register
// reset: synchronous; clears control state and all valid bits at once, no clearing pass
// top level: csr register, kra_ctrl and kra_dp; depends on kra_pkg and the macro header
`default_nettype none
`include "keyed_run_admission_table_macros.svh"

module keyed_run_admission_table (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_operation,
   input  wire logic [kra_pkg::KEY_W-1:0]           req_root_key,
   input  wire logic [kra_pkg::EPOCH_W-1:0]         req_run_epoch,
   input  wire logic                                req_trigger_is_interval,
   input  wire logic [kra_pkg::TIME_W-1:0]          req_now_us,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [kra_pkg::STATUS_W-1:0]        rsp_status,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [kra_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [kra_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic      [kra_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                     csr_pready
);

   logic [kra_pkg::TIME_W-1:0] min_interval_ff, min_interval_in;
   logic                       csr_hit;
   kra_pkg::kra_cmd_type       cmd;
   kra_pkg::kra_sts_type       sts;

   // register file
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[3] == kra_pkg::CSR_IDX_MIN_INTERVAL);

   always_comb begin
      min_interval_in = min_interval_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         min_interval_in = csr_pwdata[kra_pkg::TIME_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_hit) begin
         csr_prdata = kra_pkg::CSR_DATA_W'(min_interval_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_interval_ff <= kra_pkg::MIN_INTERVAL_RESET;
      end else begin
         min_interval_ff <= min_interval_in;
      end
   end

   kra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   kra_dp u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .sts                     (sts),
      .req_operation           (req_operation),
      .req_root_key            (req_root_key),
      .req_run_epoch           (req_run_epoch),
      .req_trigger_is_interval (req_trigger_is_interval),
      .req_now_us              (req_now_us),
      .min_interval            (min_interval_ff),
      .rsp_status              (rsp_status)
   );

   // busy from the cycle after a transfer in
   `KRA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // a new result only comes out of a busy cycle
   `KRA_ASSERT_SAME(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall))
   // idle with nothing offered gives no new result
   `KRA_ASSERT_NEXT(a_idle_quiet, clock, reset, !req_stall && !req_valid, !$rose(rsp_valid))

endmodule

`default_nettype wire
